### sv/elx_pkg.sv
package elx_pkg;

	// Width of the saturating character position counter.
	localparam int POS_BITS = 16;
	// Width of the error position field on the result channel.
	localparam int ERR_POS_W = 16;
	// Plan queue between the classifier and the result sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// Character classes kept between characters.
	typedef enum logic [1:0] {
		CLS_NUM,
		CLS_ALPHA,
		CLS_SPACE,
		CLS_OPER
	} class_t;

	// Kinds of result item.
	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_TEND,
		KIND_ERROR,
		KIND_EOS
	} kind_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;

	// Result slots of one character, in emission order from flush up to eos.
	typedef struct packed {
		logic eos;
		logic cend;
		logic err;
		logic chr;
		logic star_t;
		logic star_c;
		logic flush;
	} plan_mask_t;

	// Everything the sequencer needs to emit the results of one character.
	typedef struct packed {
		plan_mask_t mask;
		logic [7:0] ch;
		logic [ERR_POS_W-1:0] pos;
	} plan_t;

	// Operator characters that join into one token.
	function automatic logic is_oper(input logic [7:0] c);
		return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
			(c == 8'h25) || (c == 8'h5e) || (c == 8'h3d) || (c == 8'h3c) ||
			(c == 8'h3e) || (c == 8'h21);
	endfunction

endpackage

### sv/elx_if.sv
// Character channel into the lexer.
interface elx_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;
	logic last_char;

	modport source (output valid, output in_char, output last_char, input ready);
	modport sink (input valid, input in_char, input last_char, output ready);
endinterface

// Result channel out of the lexer.
interface elx_out_if import elx_pkg::*;;
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic [7:0] out_char;
	logic [ERR_POS_W-1:0] error_position;
	logic run_end;

	modport source (output valid, output out_kind, output out_char,
		output error_position, output run_end, input ready);
	modport sink (input valid, input out_kind, input out_char,
		input error_position, input run_end, output ready);
endinterface

### sv/elx_front.sv
module elx_front import elx_pkg::*; (
	input logic clk,
	input logic arst_n,
	elx_in_if.sink in_ch,
	input logic full,
	output logic push,
	output plan_t plan
);

	class_t prev_q, prev_n;
	logic open_q, open_n;
	logic quote_q, quote_n;
	logic err_q, err_n;
	logic [POS_BITS-1:0] count_q, count_inc;
	logic accept;
	logic [7:0] c;
	plan_mask_t m;
	logic old_word;

	// A character is taken whenever the plan queue has room.
	assign in_ch.ready = !full;
	assign accept = in_ch.valid && !full;
	assign c = in_ch.in_char;
	assign old_word = (prev_q == CLS_NUM) || (prev_q == CLS_ALPHA);

	// Position of this character, saturating at the counter's top value.
	assign count_inc = (count_q == {POS_BITS{1'b1}}) ? count_q : count_q + 1'b1;

	// Classify the character and work out its results and the next state.
	always_comb begin
		m = '0;
		prev_n = prev_q;
		open_n = open_q;
		quote_n = quote_q;
		err_n = err_q;
		plan.ch = c;
		priority if (err_q) begin
			plan.ch = c;
		end else if (quote_q) begin
			m.chr = 1'b1;
			open_n = 1'b1;
			if (c == CH_QUOTE) begin
				quote_n = 1'b0;
				m.cend = 1'b1;
				open_n = 1'b0;
				prev_n = CLS_SPACE;
			end
		end else if (c >= 8'h30 && c <= 8'h39) begin
			m.flush = open_q && (prev_q == CLS_OPER);
			m.chr = 1'b1;
			open_n = 1'b1;
			prev_n = CLS_NUM;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			m.flush = open_q && ((prev_q == CLS_NUM) || (prev_q == CLS_OPER));
			m.star_c = (prev_q == CLS_NUM);
			m.star_t = (prev_q == CLS_NUM);
			m.chr = 1'b1;
			open_n = 1'b1;
			prev_n = CLS_ALPHA;
		end else if (c == CH_SPACE) begin
			if (prev_q != CLS_SPACE) begin
				m.flush = open_q;
				open_n = 1'b0;
			end
			prev_n = CLS_SPACE;
		end else if (c == CH_QUOTE) begin
			m.flush = open_q;
			m.chr = 1'b1;
			open_n = 1'b1;
			quote_n = 1'b1;
			prev_n = CLS_SPACE;
		end else if (c == CH_DOT) begin
			// A dot after a number or name stays in that token.
			m.chr = 1'b1;
			open_n = 1'b1;
			if (!old_word) begin
				m.flush = open_q;
				prev_n = CLS_NUM;
			end
		end else if (c == CH_LPAREN) begin
			m.flush = open_q;
			m.star_c = old_word;
			m.star_t = old_word;
			m.chr = 1'b1;
			m.cend = 1'b1;
			open_n = 1'b0;
			prev_n = CLS_SPACE;
		end else if (c == CH_RPAREN) begin
			m.flush = open_q;
			m.chr = 1'b1;
			m.cend = 1'b1;
			open_n = 1'b0;
			prev_n = CLS_SPACE;
		end else if (is_oper(c)) begin
			m.flush = open_q && old_word;
			m.chr = 1'b1;
			open_n = 1'b1;
			prev_n = CLS_OPER;
		end else begin
			m.err = 1'b1;
			err_n = 1'b1;
		end

		// The final character closes any open token and ends the string.
		if (in_ch.last_char) begin
			m.cend = m.cend || open_n;
			m.eos = 1'b1;
		end
		plan.mask = m;
		plan.pos = m.err ? ERR_POS_W'(count_inc) : '0;
	end

	assign push = accept && (m != '0);

	// Lexer state, cleared after the final character of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CLS_SPACE;
			open_q <= 1'b0;
			quote_q <= 1'b0;
			err_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (in_ch.last_char) begin
				prev_q <= CLS_SPACE;
				open_q <= 1'b0;
				quote_q <= 1'b0;
				err_q <= 1'b0;
				count_q <= '0;
			end else begin
				prev_q <= prev_n;
				open_q <= open_n;
				quote_q <= quote_n;
				err_q <= err_n;
				count_q <= count_inc;
			end
		end
	end

endmodule

### sv/elx_queue.sv
module elx_queue import elx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input plan_t push_data,
	input logic pop,
	output plan_t head,
	output logic empty,
	output logic full
);

	plan_t entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign head = entries_q[rd_ptr_q];

	// Plan storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/elx_emit.sv
module elx_emit import elx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input plan_t head,
	input logic empty,
	output logic pop,
	elx_out_if.source out_ch
);

	plan_mask_t done_q, pend, sel, rest;
	kind_t kind;
	logic [7:0] ch;
	logic [ERR_POS_W-1:0] pos;
	logic load, last_res;
	logic valid_q, run_end_q;
	kind_t kind_q;
	logic [7:0] ch_q;
	logic [ERR_POS_W-1:0] pos_q;

	// Slots of the head plan not yet sent.
	assign pend = empty ? plan_mask_t'('0) : plan_mask_t'(head.mask & ~done_q);

	// Pick the earliest pending slot and build its result.
	always_comb begin
		sel = '0;
		kind = KIND_TEND;
		ch = '0;
		pos = '0;
		if (pend.flush) begin
			sel.flush = 1'b1;
		end else if (pend.star_c) begin
			sel.star_c = 1'b1;
			kind = KIND_CHAR;
			ch = CH_STAR;
		end else if (pend.star_t) begin
			sel.star_t = 1'b1;
		end else if (pend.chr) begin
			sel.chr = 1'b1;
			kind = KIND_CHAR;
			ch = head.ch;
		end else if (pend.err) begin
			sel.err = 1'b1;
			kind = KIND_ERROR;
			ch = head.ch;
			pos = head.pos;
		end else if (pend.cend) begin
			sel.cend = 1'b1;
		end else begin
			sel.eos = pend.eos;
			kind = KIND_EOS;
		end
	end

	assign rest = plan_mask_t'(pend & ~sel);
	assign last_res = (rest == '0);
	assign load = (pend != '0) && (!valid_q || out_ch.ready);
	assign pop = load && last_res;

	// Progress through the head plan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (load) begin
			done_q <= last_res ? plan_mask_t'('0) : plan_mask_t'(done_q | sel);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind;
			ch_q <= ch;
			pos_q <= pos;
			run_end_q <= last_res;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.out_kind = kind_q;
	assign out_ch.out_char = ch_q;
	assign out_ch.error_position = pos_q;
	assign out_ch.run_end = run_end_q;

endmodule

### sv/expression_lexer_unit.sv
// Expression lexer: takes one character per cycle while its plan queue has room
// and turns it into a stream of token characters, token ends, illegal-character
// errors and end-of-string marks. A classifier updates the lexer state in the
// cycle a character is taken and queues a plan of its results; a sequencer
// sends those results one per cycle through an output register while the
// receiver is ready. A character causes up to six results, and the four-entry
// plan queue lets further characters be taken while the sequencer works.
// Characters that cause no result do not enter the queue. An error result
// carries the 1-based position of the offending character, saturating.
module expression_lexer_unit import elx_pkg::*; (
	input logic clk,
	input logic arst_n,
	elx_in_if.sink in_ch,
	elx_out_if.source out_ch
);

	plan_t plan, q_head;
	logic q_push, q_pop, q_empty, q_full;

	elx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.full(q_full),
		.push(q_push),
		.plan(plan)
	);

	elx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(plan),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty),
		.full(q_full)
	);

	elx_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.empty(q_empty),
		.pop(q_pop),
		.out_ch(out_ch)
	);

	// An error result always names a position.
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.out_kind == KIND_ERROR |-> out_ch.error_position != '0)
		else $error("error result without a position");

	// Other results carry no position.
	a_other_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.out_kind != KIND_ERROR |-> out_ch.error_position == '0)
		else $error("position on a non-error result");

	// End of string is always the last result of its character.
	a_eos_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.out_kind == KIND_EOS |-> out_ch.run_end)
		else $error("end of string not marked as run end");

	// The sequencer never retires a plan from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_pop)
		else $error("pop from empty plan queue");

endmodule

### dv/expression_lexer_unit_tb.sv
`timescale 1ns / 1ps

module expression_lexer_unit_tb import elx_pkg::*; ();

	// One character waiting to be sent, with its pacing hints.
	typedef struct {
		logic [7:0] ch;
		logic last;
		bit drain;
		bit rush;
	} char_item_t;

	// One token stream result as the lexer should send it.
	typedef struct {
		kind_t kind;
		logic [7:0] ch;
		logic [ERR_POS_W-1:0] pos;
		logic run_end;
	} lex_result_t;

	localparam string OPER_CHARS = "+-*/%^=<>!";
	localparam string ILLEGAL_CHARS = "#$&,;:?@[]{}AZ_~'|\\";

	logic clk;
	logic arst_n;

	elx_in_if in_if ();
	elx_out_if out_if ();

	expression_lexer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	char_item_t char_queue[$];
	lex_result_t expected_results[$];
	lex_result_t step_results[$];

	// Lexer state as the block should hold it.
	class_t prev_cls = CLS_SPACE;
	bit tok_open = 1'b0;
	bit in_quote = 1'b0;
	logic [POS_BITS-1:0] char_cnt = '0;
	bit err_seen = 1'b0;

	bit in_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int in_calm = 0;
	int out_calm = 0;
	int failures = 0;
	int chars_taken = 0;
	int strings_done = 0;
	int tokens_seen = 0;
	int errors_seen = 0;
	int results_seen = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Lexer prediction helpers.
	function automatic void emit(input kind_t k, input logic [7:0] c,
		input logic [ERR_POS_W-1:0] p);
		step_results.insert(step_results.size(), '{k, c, p, 1'b0});
	endfunction

	function automatic void add_char(input logic [7:0] c);
		emit(KIND_CHAR, c, '0);
		tok_open = 1'b1;
	endfunction

	function automatic void close_token();
		if (tok_open) begin
			emit(KIND_TEND, 8'h00, '0);
			tok_open = 1'b0;
		end
	endfunction

	function automatic void single(input logic [7:0] c);
		emit(KIND_CHAR, c, '0);
		emit(KIND_TEND, 8'h00, '0);
	endfunction

	function automatic bit is_operator(input logic [7:0] c);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < OPER_CHARS.len(); i++) begin
			if (c == OPER_CHARS[i])
				hit = 1'b1;
		end
		return hit;
	endfunction

	// Works out the results of one character and advances the lexer state.
	function automatic void lex_char(input logic [7:0] c, input logic last);
		class_t was;
		was = prev_cls;
		step_results.delete();
		if (char_cnt != '1)
			char_cnt++;
		if (!err_seen) begin
			if (in_quote) begin
				add_char(c);
				if (c == CH_QUOTE) begin
					in_quote = 1'b0;
					close_token();
					prev_cls = CLS_SPACE;
				end
			end else if (c >= "0" && c <= "9") begin
				if (was == CLS_OPER)
					close_token();
				add_char(c);
				prev_cls = CLS_NUM;
			end else if (c >= "a" && c <= "z") begin
				if (was == CLS_NUM) begin
					close_token();
					single(CH_STAR);
				end else if (was == CLS_OPER) begin
					close_token();
				end
				add_char(c);
				prev_cls = CLS_ALPHA;
			end else if (c == CH_SPACE) begin
				if (was != CLS_SPACE)
					close_token();
				prev_cls = CLS_SPACE;
			end else if (c == CH_QUOTE) begin
				close_token();
				add_char(c);
				in_quote = 1'b1;
				prev_cls = CLS_SPACE;
			end else if (c == CH_DOT) begin
				// A dot extends a number or a name; elsewhere it opens a number.
				if (was == CLS_NUM || was == CLS_ALPHA) begin
					add_char(c);
				end else begin
					close_token();
					add_char(c);
					prev_cls = CLS_NUM;
				end
			end else if (c == CH_LPAREN) begin
				if (was == CLS_NUM || was == CLS_ALPHA) begin
					close_token();
					single(CH_STAR);
				end
				close_token();
				single(CH_LPAREN);
				prev_cls = CLS_SPACE;
			end else if (c == CH_RPAREN) begin
				close_token();
				single(CH_RPAREN);
				prev_cls = CLS_SPACE;
			end else if (is_operator(c)) begin
				if (was == CLS_NUM || was == CLS_ALPHA)
					close_token();
				add_char(c);
				prev_cls = CLS_OPER;
			end else begin
				emit(KIND_ERROR, c, char_cnt[ERR_POS_W-1:0]);
				err_seen = 1'b1;
			end
		end
		// The final character flushes the open token and clears the state.
		if (last) begin
			close_token();
			emit(KIND_EOS, 8'h00, '0);
			prev_cls = CLS_SPACE;
			tok_open = 1'b0;
			in_quote = 1'b0;
			char_cnt = '0;
			err_seen = 1'b0;
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].run_end = 1'b1;
	endfunction

	// Idle length for either side: mostly none, some short, a few long,
	// and now and then a calm stretch with no idling at all.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic last, input bit drain,
		input bit rush);
		char_queue.insert(char_queue.size(), '{c, last, drain, rush});
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1, 1'b0, 1'b0);
	endtask

	// Builds one random expression, mostly well formed, and queues it.
	task automatic add_random_expression(input bit drain, inout int count);
		logic [7:0] text[$];
		int pieces;
		int pick;
		int n;
		pieces = $urandom_range(1, 7);
		repeat (pieces) begin
			pick = $urandom_range(0, 99);
			if (pick < 24) begin
				n = $urandom_range(1, 4);
				repeat (n) text.insert(text.size(), 8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 3) == 0) begin
					text.insert(text.size(), CH_DOT);
					text.insert(text.size(), 8'("0" + $urandom_range(0, 9)));
				end
			end else if (pick < 46) begin
				n = $urandom_range(1, 4);
				repeat (n) text.insert(text.size(), 8'("a" + $urandom_range(0, 25)));
				if ($urandom_range(0, 5) == 0)
					text.insert(text.size(), CH_DOT);
			end else if (pick < 62) begin
				n = $urandom_range(1, 3);
				repeat (n) text.insert(text.size(), OPER_CHARS[$urandom_range(0, 9)]);
			end else if (pick < 72) begin
				n = $urandom_range(1, 2);
				repeat (n) text.insert(text.size(), CH_SPACE);
			end else if (pick < 82) begin
				text.insert(text.size(), $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
			end else if (pick < 89) begin
				// Quoted text may hold any byte and is sometimes left open.
				text.insert(text.size(), CH_QUOTE);
				n = $urandom_range(0, 4);
				repeat (n) text.insert(text.size(), 8'($urandom()));
				if ($urandom_range(0, 4) != 0)
					text.insert(text.size(), CH_QUOTE);
			end else if (pick < 94) begin
				text.insert(text.size(), CH_DOT);
			end else if (pick < 97) begin
				text.insert(text.size(), 8'($urandom()));
			end else begin
				if ($urandom_range(0, 1))
					text.insert(text.size(),
						ILLEGAL_CHARS[$urandom_range(0, ILLEGAL_CHARS.len() - 1)]);
				else
					text.insert(text.size(), 8'($urandom_range(128, 255)));
			end
		end
		foreach (text[i])
			queue_char(text[i], i == text.size() - 1, drain && i == 0, 1'b0);
		count += text.size();
	endtask

	// Character driver: presents queued items with random gaps.
	always @(negedge clk) begin
		char_item_t item;
		if (arst_n) begin
			if (in_if.valid && !in_taken) begin
				// The current item has not been taken yet.
			end else if (gap_left > 0) begin
				gap_left--;
				in_if.valid <= 1'b0;
			end else if (char_queue.size() > 0 &&
				!(char_queue[0].drain && expected_results.size() > 0)) begin
				item = char_queue.pop_front();
				in_if.valid <= 1'b1;
				in_if.in_char <= item.ch;
				in_if.last_char <= item.last;
				gap_left = item.rush ? 0 : idle_len(in_calm);
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Result consumer: ready with random stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
				stall_left = idle_len(out_calm);
			end
		end
	end

	// Monitor: predicts on every taken character and checks every result.
	always @(posedge clk) begin
		lex_result_t want;
		in_taken = arst_n && in_if.valid && in_if.ready;
		if (in_taken) begin
			chars_taken++;
			lex_char(in_if.in_char, in_if.last_char);
			foreach (step_results[i])
				expected_results.insert(expected_results.size(), step_results[i]);
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result kind %0d char %h pos %0d end %0b", $realtime,
					out_if.out_kind, out_if.out_char, out_if.error_position, out_if.run_end);
			end else begin
				want = expected_results.pop_front();
				if (out_if.out_kind !== want.kind || out_if.out_char !== want.ch ||
					out_if.error_position !== want.pos || out_if.run_end !== want.run_end) begin
					failures++;
					$display({"%0t: expected kind %0d char %h pos %0d end %0b, ",
						"got kind %0d char %h pos %0d end %0b"},
						$realtime, want.kind, want.ch, want.pos, want.run_end, out_if.out_kind,
						out_if.out_char, out_if.error_position, out_if.run_end);
				end
				case (want.kind)
					KIND_TEND: tokens_seen++;
					KIND_ERROR: errors_seen++;
					KIND_EOS: strings_done++;
					default: ;
				endcase
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int random_count;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.in_char = 8'h00;
		in_if.last_char = 1'b0;
		out_if.ready = 1'b0;
		random_count = 0;

		// Directed strings: implicit multiplies, dots, operator runs, quotes,
		// errors and the extreme byte values.
		queue_text("9z(");
		queue_text("1.a+=-x");
		queue_text(".)");
		queue_text("\"a#\"");
		queue_text("\"ab");
		queue_text("1#2");
		queue_char(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_char(8'h00, 1'b1, 1'b0, 1'b0);
		queue_text("x");
		queue_text(" ");

		// Random expressions; the first one waits for the lexer to drain.
		add_random_expression(1'b1, random_count);
		while (random_count < 404)
			add_random_expression($urandom_range(0, 9) == 0, random_count);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_queue.size() > 0 || in_if.valid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Lexed %0d characters in %0d strings: %0d results, %0d tokens, %0d errors.",
			chars_taken, strings_done, results_seen, tokens_seen, errors_seen);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
